[src/smrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrc_pkg
// Shared types, constants and helpers of the stepper move ramp controller.
// ----------------------------------------------------------------------------
package smrc_pkg;

    localparam int DEF_RATE_FRAC_BITS = 8;
    localparam int DEF_MAX_RATE       = 250000;

    localparam int RATE_W    = 26;
    localparam int VEL_W     = 16;
    localparam int COUNT_W   = 32;
    localparam int PERIOD_W  = 32;
    localparam int CLK_W     = 32;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 104;

    localparam logic [CLK_W-1:0]    RESET_TIMER_CLOCK = CLK_W'(1000000);
    localparam logic [CODE_W-1:0]   MAX_CODE = CODE_W'(5);

    typedef enum logic [1:0] {
        CMD_FINITE = 2'd0,
        CMD_CONT   = 2'd1,
        CMD_STEP   = 2'd2,
        CMD_ACCEL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        LVL_OFF    = 2'd0,
        LVL_MOVING = 2'd1,
        LVL_HOLD   = 2'd2
    } t_level;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MICROSTEP = 2'd0,
        CFG_ACCEL     = 2'd1,
        CFG_TIMER_CLK = 2'd2,
        CFG_SPARE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PREP = 2'd1,
        ST_DIV  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    function automatic logic [CODE_W-1:0] eff_code(input logic [CODE_W-1:0] code);
        eff_code = (code > MAX_CODE) ? MAX_CODE : code;
    endfunction

    function automatic logic [2:0] mode_pins_for(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        c = eff_code(code);
        case (c)
            3'd0:    mode_pins_for = 3'b000;
            3'd1:    mode_pins_for = 3'b001;
            3'd2:    mode_pins_for = 3'b010;
            3'd3:    mode_pins_for = 3'b011;
            3'd4:    mode_pins_for = 3'b100;
            default: mode_pins_for = 3'b111;
        endcase
    endfunction

endpackage

[src/smrc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrc_div
// Restoring bit-serial divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module smrc_div #(
    parameter int DIVD_W = 41,
    parameter int DIVS_W = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVD_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/stepper_move_ramp_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_move_ramp_controller
// Step and direction move controller with a linear acceleration ramp.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel; tuser carries the command kind and
// tdata the direction, velocity and step count. Every transaction yields
// exactly one status transaction on the m_axis channel with the pin levels,
// the step period, the remaining steps, the present rate and current level.
// The result is registered and valid in the cycle after the input transaction,
// except for an accel tick that finds the motor running below its target
// rate: it also reloads the step period, where a zero new rate gives all ones
// without the divider and any other rate runs a bit-serial divider of one
// quotient bit per cycle before the result. s_axis_tready is low from
// acceptance until the cycle after the result transaction, so a new command
// is not taken before the result of the last one. The result is held stable
// while m_axis_tready is low, but mode_pins follow the microstep register.
// Synchronous reset clears the motion state, stops the motor, sets the current
// request off and the step period to all ones; the timer clock register resets
// to 1 MHz. Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data.
// ----------------------------------------------------------------------------
module stepper_move_ramp_controller #(
    parameter int RATE_FRAC_BITS = smrc_pkg::DEF_RATE_FRAC_BITS,
    parameter int MAX_RATE       = smrc_pkg::DEF_MAX_RATE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [smrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [smrc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] direction, [16:1] velocity, [48:17] step_count, rest zero
    input  logic [smrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] status, [1] drive_enable, [2] running, [3] direction_level,
    // [6:4] mode_pins, [38:7] step_period, [70:39] steps_left,
    // [96:71] current_rate, [98:97] current_level, rest zero
    output logic [smrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import smrc_pkg::*;

    localparam int DIVD_W   = CLK_W + RATE_FRAC_BITS + 1;
    localparam int VSH_W    = VEL_W + 5;
    localparam int WIDE_W   = VSH_W + RATE_W;
    localparam logic [VSH_W-1:0] MAX_RATE_V = VSH_W'(MAX_RATE);

    // Configuration registers.
    logic [CODE_W-1:0]   r_ms_code;
    logic [RATE_W-1:0]   r_accel_step;
    logic [CLK_W-1:0]    r_timer_clock;

    // Motion state.
    t_state              r_state, n_state;
    logic                r_run, n_run;
    logic                r_finite, n_finite;
    logic                r_dir, n_dir;
    logic [COUNT_W-1:0]  r_remaining, n_remaining;
    logic [RATE_W-1:0]   r_target, n_target;
    logic [RATE_W-1:0]   r_present, n_present;
    logic [PERIOD_W-1:0] r_period, n_period;
    t_level              r_level, n_level;
    logic                r_status, n_status;

    // Input fields.
    t_cmd                in_cmd;
    logic                in_dir;
    logic [VEL_W-1:0]    in_vel;
    logic [COUNT_W-1:0]  in_cnt;

    logic [VSH_W-1:0]    vel_sh;
    logic [VSH_W-1:0]    vel_clamp;
    logic [WIDE_W-1:0]   vel_wide;
    logic [RATE_W:0]     rate_sum;
    logic [COUNT_W-1:0]  rem_dec;
    logic                accepted;

    logic                div_start;
    logic                div_done;
    logic [DIVD_W-1:0]   div_dividend;
    logic [DIVD_W-1:0]   div_quotient;
    logic [PERIOD_W-1:0] div_period;

    assign in_cmd = t_cmd'(s_axis_tuser);
    assign in_dir = s_axis_tdata[0];
    assign in_vel = s_axis_tdata[VEL_W:1];
    assign in_cnt = s_axis_tdata[VEL_W+COUNT_W:VEL_W+1];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accepted      = s_axis_tvalid && s_axis_tready;

    assign vel_sh    = VSH_W'(in_vel) << eff_code(r_ms_code);
    assign vel_clamp = (vel_sh > MAX_RATE_V) ? MAX_RATE_V : vel_sh;
    assign vel_wide  = WIDE_W'(vel_clamp) << RATE_FRAC_BITS;
    assign rate_sum  = {1'b0, r_present} + {1'b0, r_accel_step};
    assign rem_dec   = (r_remaining != '0) ? (r_remaining - COUNT_W'(1)) : '0;

    assign div_dividend = {1'b0, r_timer_clock, {RATE_FRAC_BITS{1'b0}}}
                        + DIVD_W'(r_present[RATE_W-1:1]);
    assign div_period   = (div_quotient[DIVD_W-1:PERIOD_W] != '0) ? '1
                        : div_quotient[PERIOD_W-1:0];

    smrc_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (RATE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_present),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_code     <= '0;
            r_accel_step  <= '0;
            r_timer_clock <= RESET_TIMER_CLOCK;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MICROSTEP: r_ms_code     <= i_cfg_data[CODE_W-1:0];
                CFG_ACCEL:     r_accel_step  <= i_cfg_data[RATE_W-1:0];
                CFG_TIMER_CLK: r_timer_clock <= i_cfg_data[CLK_W-1:0];
                default:       r_ms_code     <= r_ms_code;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= 1'b0;
            r_finite    <= 1'b0;
            r_dir       <= 1'b0;
            r_remaining <= '0;
            r_target    <= '0;
            r_present   <= '0;
            r_period    <= '1;
            r_level     <= LVL_OFF;
            r_status    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_finite    <= n_finite;
            r_dir       <= n_dir;
            r_remaining <= n_remaining;
            r_target    <= n_target;
            r_present   <= n_present;
            r_period    <= n_period;
            r_level     <= n_level;
            r_status    <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_finite    = r_finite;
        n_dir       = r_dir;
        n_remaining = r_remaining;
        n_target    = r_target;
        n_present   = r_present;
        n_period    = r_period;
        n_level     = r_level;
        n_status    = r_status;
        div_start   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accepted) begin
                    n_status = 1'b0;
                    n_state  = ST_OUT;
                    case (in_cmd)
                        CMD_FINITE, CMD_CONT: begin
                            n_finite = (in_cmd == CMD_FINITE);
                            if (in_cmd == CMD_FINITE) begin
                                n_remaining = in_cnt;
                            end
                            if (in_vel == '0) begin
                                n_status = 1'b1;
                            end else begin
                                n_target = vel_wide[RATE_W-1:0];
                            end
                            n_dir   = in_dir;
                            n_run   = 1'b1;
                            n_level = LVL_MOVING;
                        end
                        CMD_STEP: begin
                            if (r_run && r_finite) begin
                                n_remaining = rem_dec;
                                if (rem_dec == '0) begin
                                    n_run   = 1'b0;
                                    n_level = LVL_HOLD;
                                end
                            end
                        end
                        default: begin
                            if (r_run && (r_present < r_target)) begin
                                n_present = (rate_sum > {1'b0, r_target}) ? r_target
                                          : rate_sum[RATE_W-1:0];
                                n_state   = ST_PREP;
                            end
                        end
                    endcase
                end
            end
            ST_PREP: begin
                if (r_present == '0) begin
                    n_period = '1;
                    n_state  = ST_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_period = div_period;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {5'd0, r_level, r_present, r_remaining, r_period,
                            mode_pins_for(r_ms_code), r_dir, r_run,
                            (r_level != LVL_OFF), r_status};

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stepper move ramp controller.
// ----------------------------------------------------------------------------
// A directed sequence covers ticks while stopped, zero velocity moves,
// zero-step moves, a ramp stuck at zero rate, period saturation, a zero
// timer clock and microstep codes above five. Randomized phases follow, with
// new register settings between them. Most of the traffic is moves followed
// by runs of step and accel ticks, and the rest is random noise. A scoreboard
// predicts the status transaction of every accepted command and checks the
// results in order. Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_top;
    import smrc_pkg::*;

    localparam int GAP_MAX       = 11;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic                status;
        logic                drive_enable;
        logic                running;
        logic                direction_level;
        logic [2:0]          mode_pins;
        logic [PERIOD_W-1:0] step_period;
        logic [COUNT_W-1:0]  steps_left;
        logic [RATE_W-1:0]   current_rate;
        logic [1:0]          current_level;
        logic [4:0]          pad;
    } t_move_status;

    class move_status_scoreboard;
        logic [CODE_W-1:0]   code;
        logic [RATE_W-1:0]   accel_step;
        logic [CLK_W-1:0]    timer_clock;
        bit                  run;
        bit                  finite;
        logic                dir;
        logic [COUNT_W-1:0]  remaining;
        logic [RATE_W-1:0]   target_rate;
        logic [RATE_W-1:0]   present_rate;
        logic [PERIOD_W-1:0] period;
        t_level              level;
        t_move_status        expected_status[$];
        int                  errors;

        function new();
            code         = '0;
            accel_step   = '0;
            timer_clock  = RESET_TIMER_CLOCK;
            run          = 1'b0;
            finite       = 1'b0;
            dir          = 1'b0;
            remaining    = '0;
            target_rate  = '0;
            present_rate = '0;
            period       = '1;
            level        = LVL_OFF;
            errors       = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_MICROSTEP: code = value[CODE_W-1:0];
                CFG_ACCEL:     accel_step = value[RATE_W-1:0];
                CFG_TIMER_CLK: timer_clock = value;
                default: ;
            endcase
        endfunction

        function logic [PERIOD_W-1:0] period_from_rate(logic [RATE_W-1:0] rate);
            logic [63:0] num;
            logic [63:0] quot;
            if (rate == '0)
                return '1;
            num  = 64'(timer_clock) << DEF_RATE_FRAC_BITS;
            quot = (num + 64'(rate >> 1)) / 64'(rate);
            if (quot > 64'hFFFF_FFFF)
                return '1;
            return quot[PERIOD_W-1:0];
        endfunction

        function void note_command(t_cmd cmd, logic dir_in, logic [VEL_W-1:0] vel,
                                   logic [COUNT_W-1:0] cnt);
            logic [63:0]       wide;
            logic [CODE_W-1:0] eff;
            t_move_status      e;
            e.status = 1'b0;
            eff = (code > MAX_CODE) ? MAX_CODE : code;
            case (cmd)
                CMD_FINITE, CMD_CONT: begin
                    finite = (cmd == CMD_FINITE);
                    if (finite)
                        remaining = cnt;
                    if (vel == '0) begin
                        e.status = 1'b1;
                    end else begin
                        wide = 64'(vel) << eff;
                        if (wide > 64'(DEF_MAX_RATE))
                            wide = 64'(DEF_MAX_RATE);
                        target_rate = RATE_W'(wide << DEF_RATE_FRAC_BITS);
                    end
                    dir   = dir_in;
                    run   = 1'b1;
                    level = LVL_MOVING;
                end
                CMD_STEP: begin
                    if (run && finite) begin
                        if (remaining != '0)
                            remaining = remaining - 1'b1;
                        if (remaining == '0) begin
                            run   = 1'b0;
                            level = LVL_HOLD;
                        end
                    end
                end
                default: begin
                    if (run && present_rate < target_rate) begin
                        wide = 64'(present_rate) + 64'(accel_step);
                        if (wide > 64'(target_rate))
                            wide = 64'(target_rate);
                        present_rate = wide[RATE_W-1:0];
                        period       = period_from_rate(present_rate);
                    end
                end
            endcase
            e.drive_enable    = (level != LVL_OFF);
            e.running         = run;
            e.direction_level = dir;
            e.mode_pins       = (eff == MAX_CODE) ? 3'b111 : eff;
            e.step_period     = period;
            e.steps_left      = remaining;
            e.current_rate    = present_rate;
            e.current_level   = level;
            e.pad             = '0;
            expected_status.push_back(e);
        endfunction

        function void compare_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
            end
        endfunction

        function void check_status(logic [OUT_DATA_W-1:0] data);
            t_move_status e;
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t: result transaction with none expected, actual %h",
                         $time, data);
                return;
            end
            e = expected_status.pop_front();
            compare_field("status", 64'(e.status), 64'(data[0]));
            compare_field("drive_enable", 64'(e.drive_enable), 64'(data[1]));
            compare_field("running", 64'(e.running), 64'(data[2]));
            compare_field("direction_level", 64'(e.direction_level), 64'(data[3]));
            compare_field("mode_pins", 64'(e.mode_pins), 64'(data[6:4]));
            compare_field("step_period", 64'(e.step_period), 64'(data[38:7]));
            compare_field("steps_left", 64'(e.steps_left), 64'(data[70:39]));
            compare_field("current_rate", 64'(e.current_rate), 64'(data[96:71]));
            compare_field("current_level", 64'(e.current_level), 64'(data[98:97]));
            compare_field("pad", 64'(e.pad), 64'(data[OUT_DATA_W-1:99]));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    move_status_scoreboard sb = new();
    bit                    no_idle = 1'b0;
    int                    idle_cycles = 0;

    stepper_move_ramp_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
            sb.check_status(m_axis_tdata);
            @(negedge i_clk);
        end
    end

    task automatic send_command(t_cmd cmd, logic dir_in, logic [VEL_W-1:0] vel,
                                logic [COUNT_W-1:0] cnt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_W'({cnt, vel, dir_in});
        do @(posedge i_clk);
        while (!(s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1));
        sb.note_command(cmd, dir_in, vel, cnt);
        @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_traffic(int n_items);
        int               sent;
        int               ticks;
        logic [VEL_W-1:0] vel;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 3) begin
                send_command(t_cmd'($urandom_range(0, 3)), 1'($urandom), 16'($urandom),
                             $urandom);
                sent++;
            end else begin
                if ($urandom_range(0, 19) == 0)
                    vel = '0;
                else
                    vel = 16'($urandom_range(1, (1 << $urandom_range(1, 16)) - 1));
                send_command($urandom_range(0, 1) ? CMD_CONT : CMD_FINITE, 1'($urandom),
                             vel, $urandom_range(0, 12));
                sent++;
                ticks = $urandom_range(1, 16);
                repeat (ticks) begin
                    send_command($urandom_range(0, 2) == 0 ? CMD_ACCEL : CMD_STEP,
                                 1'($urandom), 16'($urandom), $urandom);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] clk_val;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ticks while stopped, zero velocity, a zero-step move
        // and a ramp that cannot leave zero rate.
        send_command(CMD_STEP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_ACCEL, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_CONT, 1'b1, 16'h0000, 32'h0000_0000);
        send_command(CMD_ACCEL, 1'b0, 16'h0000, 32'h0000_0000);
        send_command(CMD_FINITE, 1'b0, 16'hFFFF, 32'h0000_0000);
        send_command(CMD_ACCEL, 1'b0, 16'h0000, 32'h0000_0000);
        send_command(CMD_STEP, 1'b0, 16'h0000, 32'h0000_0000);
        send_command(CMD_STEP, 1'b0, 16'h0000, 32'h0000_0000);
        settle_block();

        // Code seven, slowest ramp and the largest timer clock saturate the period.
        write_register(CFG_MICROSTEP, 32'd7);
        write_register(CFG_ACCEL, 32'd1);
        write_register(CFG_TIMER_CLK, 32'hFFFF_FFFF);
        write_register(CFG_SPARE, $urandom);
        send_command(CMD_FINITE, 1'b1, 16'd1, 32'd2);
        send_command(CMD_ACCEL, 1'b0, 16'd0, 32'd0);
        send_command(CMD_STEP, 1'b0, 16'd0, 32'd0);
        send_command(CMD_STEP, 1'b0, 16'd0, 32'd0);
        send_command(CMD_ACCEL, 1'b0, 16'd0, 32'd0);
        settle_block();

        // A zero timer clock, code six and a continuous move.
        write_register(CFG_TIMER_CLK, 32'd0);
        write_register(CFG_MICROSTEP, 32'd6);
        write_register(CFG_ACCEL, 32'd100);
        send_command(CMD_CONT, 1'b0, 16'd3, 32'hFFFF_FFFF);
        send_command(CMD_ACCEL, 1'b1, 16'd0, 32'd0);
        send_command(CMD_STEP, 1'b1, 16'd0, 32'd0);
        settle_block();

        // The smallest timer clock, a saturated target and a huge finite move.
        write_register(CFG_TIMER_CLK, 32'd1);
        write_register(CFG_MICROSTEP, 32'd4);
        write_register(CFG_ACCEL, 32'h3FF);
        send_command(CMD_CONT, 1'b1, 16'hFFFF, 32'd0);
        send_command(CMD_ACCEL, 1'b0, 16'd0, 32'd0);
        send_command(CMD_FINITE, 1'b0, 16'h8000, 32'hFFFF_FFFF);
        send_command(CMD_STEP, 1'b0, 16'd0, 32'd0);
        send_command(CMD_FINITE, 1'b1, 16'h0000, 32'd5);
        send_command(CMD_CONT, 1'b0, 16'd1, 32'd0);
        settle_block();

        // The present rate never falls, so the ramp step grows from phase to phase.
        for (int p = 0; p < 8; p++) begin
            no_idle = (p % 3 == 2);
            case ($urandom_range(0, 3))
                0:       clk_val = 32'd1;
                1:       clk_val = 32'hFFFF_FFFF;
                2:       clk_val = RESET_TIMER_CLOCK;
                default: clk_val = $urandom;
            endcase
            write_register(CFG_MICROSTEP, ($urandom & ~32'h7) | 32'(p));
            write_register(CFG_ACCEL, ($urandom & 32'hFC00_0000)
                                      | 32'($urandom_range(0, (1 << (4 + 2 * p)) - 1)));
            write_register(CFG_TIMER_CLK, clk_val);
            random_traffic(100);
            settle_block();
        end

        // Largest ramp step carries the rate straight to its ceiling.
        no_idle = 1'b0;
        write_register(CFG_ACCEL, 32'hFFFF_FFFF);
        write_register(CFG_MICROSTEP, 32'd5);
        write_register(CFG_TIMER_CLK, $urandom);
        send_command(CMD_CONT, 1'b0, 16'hFFFF, 32'd0);
        send_command(CMD_ACCEL, 1'b0, 16'd0, 32'd0);
        send_command(CMD_ACCEL, 1'b1, 16'd0, 32'd0);
        random_traffic(20);
        settle_block();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_status.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
src/smrc_pkg.sv
src/smrc_div.sv
src/stepper_move_ramp_controller.sv
test/tb_top.sv
